FILE: src/sedef_pkg.sv
package sedef_pkg;

  localparam int Dim = 3;
  localparam int MaxPoints = 16;
  localparam int MaxShapes = 16;
  localparam int NFunc = Dim + 1;

  localparam int ShW = 4;
  localparam int PtW = 4;
  localparam int FnW = 2;
  localparam int KW = 2;

  localparam int CoefDepth = NFunc * MaxShapes;
  localparam int CoefAw = $clog2(CoefDepth);
  localparam int GradDepth = MaxPoints * MaxShapes * Dim;
  localparam int GradAw = $clog2(GradDepth);
  localparam int PshDepth = MaxPoints * MaxShapes;
  localparam int PshAw = $clog2(PshDepth);
  localparam int AccDepth = NFunc * MaxShapes;
  localparam int AccAw = $clog2(AccDepth);

  localparam logic [1:0] CMD_COEF = 2'd0;
  localparam logic [1:0] CMD_SHAPE = 2'd1;
  localparam logic [1:0] CMD_POINT = 2'd2;
  localparam logic [1:0] CMD_COMPUTE = 2'd3;

  localparam logic [1:0] REG_POINTS = 2'd0;
  localparam logic [1:0] REG_VSHAPES = 2'd1;
  localparam logic [1:0] REG_PSHAPES = 2'd2;

  localparam logic signed [47:0] AccMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] AccMin = 48'sh8000_0000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    if (x > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -48'sh0000_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
    if (x > 49'(AccMax)) return AccMax;
    if (x < 49'(AccMin)) return AccMin;
    return x[47:0];
  endfunction

  // floor(a*b/2^16) saturated to 32 bits
  function automatic logic signed [31:0] mulq_fin(input logic signed [63:0] prod);
    logic signed [47:0] sh;
    sh = prod[63:16];
    return sat32(sh);
  endfunction

  function automatic logic [4:0] clamp_count(input logic [4:0] v, input int lim);
    logic [4:0] hi;
    hi = (lim < 16) ? 5'(lim) : 5'd16;
    if (v < 5'd1) return 5'd1;
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

FILE: src/sedef_ram.sv
module sedef_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: src/stokes_element_defect_assembly_core.sv
// channel  direction  handshake                 payload
// in       input      in_valid / in_ready       cmd .. viscosity
// out      output     out_valid / out_ready     out_func, out_shape, defect_value, last_flag
// cfg      input      cfg_valid / cfg_ready     cfg_index, cfg_data
// coefficient and point loads are written as the command is accepted; a shape load writes
// its three gradient lanes, one gradient lane a cycle. a compute clears the 64 accumulators,
// then runs each point on the one shared multiplier. each emitted entry is read (S_ERD),
// registered (S_EWAIT) and held in S_EOUT until out_ready. in_ready and cfg_ready stay
// low until a shape load or a compute is done. rst synchronous, active high.
module stokes_element_defect_assembly_core
  import sedef_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [1:0]         func_index,
  input  logic [3:0]         shape_index,
  input  logic [3:0]         point_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] grad_x,
  input  logic signed [31:0] grad_y,
  input  logic signed [31:0] grad_z,
  input  logic signed [31:0] pres_shape_value,
  input  logic signed [31:0] quad_weight,
  input  logic signed [31:0] viscosity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_func,
  output logic [3:0]         out_shape,
  output logic signed [31:0] defect_value,
  output logic               last_flag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // top-level states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GRADW = 4'd1;
  localparam logic [3:0] S_CLR = 4'd2;
  localparam logic [3:0] S_PT = 4'd3;
  localparam logic [3:0] S_RD = 4'd4;
  localparam logic [3:0] S_M1 = 4'd5;
  localparam logic [3:0] S_M2 = 4'd6;
  localparam logic [3:0] S_M3 = 4'd7;
  localparam logic [3:0] S_NEXT = 4'd8;
  localparam logic [3:0] S_ERD = 4'd9;
  localparam logic [3:0] S_EWAIT = 4'd10;
  localparam logic [3:0] S_EOUT = 4'd11;
  localparam logic [3:0] S_ACC = 4'd12;

  // phases of one point
  localparam logic [2:0] PH_NW = 3'd0;   // nw = mul(nu, w)
  localparam logic [2:0] PH_PR = 3'd1;   // pressure interpolation
  localparam logic [2:0] PH_DV = 3'd2;   // divergence
  localparam logic [2:0] PH_DW = 3'd3;   // dw = mul(dv, w)
  localparam logic [2:0] PH_LAP = 3'd4;  // lap sums and velocity rows
  localparam logic [2:0] PH_PRS = 3'd5;  // pressure rows

  logic [3:0] state;
  logic [2:0] phase;
  logic [4:0] point_count, vel_shape_count, pres_shape_count;
  logic [4:0] np, nv, npr;

  logic [PtW-1:0] p;
  logic [1:0] vd;      // velocity row component
  logic [ShW-1:0] vs;  // row shape
  logic [ShW-1:0] us;  // inner shape
  logic [KW-1:0] k;
  logic [1:0] sub;     // sub step inside a multiply chain
  logic [AccAw-1:0] acnt;
  logic [1:0] gk;      // gradient write lane

  logic signed [31:0] w, nw, pr, dv, dw, ta, tb, tc;
  logic signed [47:0] sum, acc_r;
  logic signed [63:0] prod;
  logic signed [31:0] ma, mb;

  // stored input for multi-cycle gradient writes
  logic signed [31:0] gy_h, gz_h;
  logic [PtW+ShW-1:0] gbase;

  logic [1:0] o_f;
  logic [ShW-1:0] o_s;

  // memories
  logic coef_we; logic [CoefAw-1:0] coef_wa, coef_ra; logic [31:0] coef_rd;
  logic grad_we; logic [GradAw-1:0] grad_wa, grad_ra; logic [31:0] grad_rd;
  logic psh_we; logic [PshAw-1:0] psh_wa, psh_ra; logic [31:0] psh_rd;
  logic pt_we; logic [PtW-1:0] pt_ra; logic [63:0] pt_rd;
  logic acc_we; logic [AccAw-1:0] acc_wa, acc_ra; logic [47:0] acc_wd, acc_rd;

  sedef_ram #(.Width(32), .Depth(CoefDepth)) u_coef (.clk, .we(coef_we), .waddr(coef_wa),
    .wdata(coef_value), .raddr(coef_ra), .rdata(coef_rd));
  sedef_ram #(.Width(32), .Depth(GradDepth)) u_grad (.clk, .we(grad_we), .waddr(grad_wa),
    .wdata(gk == 2'd0 ? grad_x : (gk == 2'd1 ? gy_h : gz_h)), .raddr(grad_ra),
    .rdata(grad_rd));
  sedef_ram #(.Width(32), .Depth(PshDepth)) u_psh (.clk, .we(psh_we), .waddr(psh_wa),
    .wdata(pres_shape_value), .raddr(psh_ra), .rdata(psh_rd));
  sedef_ram #(.Width(64), .Depth(MaxPoints)) u_pt (.clk, .we(pt_we),
    .waddr(point_index[PtW-1:0]), .wdata({viscosity, quad_weight}), .raddr(pt_ra),
    .rdata(pt_rd));
  sedef_ram #(.Width(48), .Depth(AccDepth)) u_acc (.clk, .we(acc_we), .waddr(acc_wa),
    .wdata(acc_wd), .raddr(acc_ra), .rdata(acc_rd));

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  wire in_go = in_valid && in_ready;

  function automatic logic [GradAw-1:0] gaddr(input logic [PtW-1:0] pp,
      input logic [ShW-1:0] ss, input logic [KW-1:0] kk);
    return GradAw'((32'(pp) * MaxShapes + 32'(ss)) * Dim + 32'(kk));
  endfunction

  // multiplier is the one shared unit
  assign prod = 64'(ma) * 64'(mb);
  logic signed [31:0] mres;
  assign mres = mulq_fin(prod);

  // memory write controls
  always_comb begin
    coef_we = in_go && cmd == CMD_COEF && func_index <= 2'(Dim);
    coef_wa = CoefAw'(32'(func_index) * MaxShapes + 32'(shape_index));
    psh_we = in_go && cmd == CMD_SHAPE;
    psh_wa = {point_index, shape_index};
    pt_we = in_go && cmd == CMD_POINT;
    grad_we = (in_go && cmd == CMD_SHAPE) || state == S_GRADW;
    grad_wa = (state == S_GRADW) ? gaddr(gbase[PtW+ShW-1:ShW], gbase[ShW-1:0], gk)
                                 : gaddr(point_index, shape_index, 2'd0);
  end

  // read addresses follow the current step
  always_comb begin
    coef_ra = '0; grad_ra = '0; psh_ra = {p, us}; pt_ra = p;
    acc_ra = acnt;
    unique case (phase)
      PH_PR: begin
        coef_ra = CoefAw'(Dim * MaxShapes + 32'(us));
      end
      PH_DV: begin
        coef_ra = CoefAw'(32'(k) * MaxShapes + 32'(us));
        grad_ra = gaddr(p, us, k);
      end
      PH_LAP: begin
        coef_ra = CoefAw'(32'(vd) * MaxShapes + 32'(us));
        // sub 0 reads g(us,k); sub 1 reads g(vs,k); sub 2 reads g(vs,vd)
        grad_ra = (sub == 2'd0) ? gaddr(p, us, k)
                : (sub == 2'd1) ? gaddr(p, vs, k) : gaddr(p, vs, KW'(vd));
        acc_ra = AccAw'(32'(vd) * MaxShapes + 32'(vs));
      end
      PH_PRS: begin
        psh_ra = {p, vs};
        acc_ra = AccAw'(Dim * MaxShapes + 32'(vs));
      end
      default: ;
    endcase
    if (state == S_ERD || state == S_EOUT)
      acc_ra = AccAw'(32'(o_f) * MaxShapes + 32'(o_s));
  end

  logic signed [47:0] add_a;
  logic signed [31:0] add_b;
  logic add_sub;
  logic signed [47:0] add_r;
  assign add_r = sat48(add_sub ? 49'(add_a) - 49'(add_b) : 49'(add_a) + 49'(add_b));

  logic last_vs, last_us, last_k, last_ps;
  assign last_k = (32'(k) == Dim - 1);
  assign last_us = (5'(us) + 5'd1 == nv);
  assign last_vs = (5'(vs) + 5'd1 == nv);
  assign last_ps = (5'(us) + 5'd1 == npr);

  always_comb begin
    ma = ta; mb = tb;
    add_a = sum; add_b = mres; add_sub = 1'b0;
    acc_we = 1'b0; acc_wa = acnt; acc_wd = '0;
    if (state == S_CLR) acc_we = 1'b1;
    if (state == S_ACC) begin
      acc_wa = (phase == PH_PRS) ? AccAw'(Dim * MaxShapes + 32'(vs))
                                 : AccAw'(32'(vd) * MaxShapes + 32'(vs));
      add_a = acc_r;
      if (phase == PH_PRS) begin
        add_b = mres; acc_we = 1'b1; acc_wd = add_r;
      end else if (sub == 2'd1) begin
        add_b = mres; acc_wd = add_r;
      end else begin
        add_b = mres; add_sub = 1'b1; acc_we = 1'b1; acc_wd = add_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      gk <= 2'd0;
      point_count <= 5'd1;
      vel_shape_count <= 5'd8;
      pres_shape_count <= 5'd8;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_POINTS: point_count <= cfg_data[4:0];
          REG_VSHAPES: vel_shape_count <= cfg_data[4:0];
          REG_PSHAPES: pres_shape_count <= cfg_data[4:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_go) begin
          if (cmd == CMD_SHAPE) begin
            gy_h <= grad_y; gz_h <= grad_z; gbase <= {point_index, shape_index};
            gk <= 2'd1; state <= S_GRADW;
          end else if (cmd == CMD_COMPUTE) begin
            np <= clamp_count(point_count, MaxPoints);
            nv <= clamp_count(vel_shape_count, MaxShapes);
            npr <= clamp_count(pres_shape_count, MaxShapes);
            acnt <= '0; state <= S_CLR;
          end
        end else gk <= 2'd0;
        S_GRADW: begin
          if (32'(gk) + 1 >= Dim) begin gk <= 2'd0; state <= S_IDLE; end
          else gk <= gk + 2'd1;
        end
        S_CLR: begin
          acnt <= acnt + 1'b1;
          if (32'(acnt) == AccDepth - 1) begin p <= '0; state <= S_PT; end
        end
        S_PT: begin
          // point data read issued; start with nw
          phase <= PH_NW; sub <= 2'd0; us <= '0; k <= '0; vs <= '0; vd <= '0;
          sum <= '0; state <= S_RD;
        end
        S_RD: state <= S_M1;  // read latency
        S_M1: begin
          unique case (phase)
            PH_NW: begin
              w <= pt_rd[31:0]; ta <= pt_rd[63:32]; tb <= pt_rd[31:0]; state <= S_M2;
            end
            PH_PR: begin ta <= coef_rd; tb <= psh_rd; state <= S_M2; end
            PH_DV: begin ta <= coef_rd; tb <= grad_rd; state <= S_M2; end
            PH_DW: begin ta <= dv; tb <= w; state <= S_M2; end
            PH_LAP: begin
              unique case (sub)
                2'd0: begin tc <= coef_rd; ta <= grad_rd; sub <= 2'd1; state <= S_RD; end
                2'd1: begin tb <= grad_rd; state <= S_M2; end
                default: begin ta <= pr; tb <= grad_rd; state <= S_M2; end
              endcase
            end
            default: begin ta <= dw; tb <= psh_rd; acc_r <= acc_rd; state <= S_M2; end
          endcase
        end
        S_M2: begin
          unique case (phase)
            PH_NW: begin nw <= mres; phase <= PH_PR; state <= S_RD; end
            PH_PR: begin
              if (last_ps) begin
                pr <= sat32(add_r); sum <= '0; us <= '0; phase <= PH_DV;
              end else begin sum <= add_r; us <= us + 1'b1; end
              state <= S_RD;
            end
            PH_DV: begin
              if (last_k && last_us) begin
                dv <= sat32(add_r); sum <= '0; us <= '0; k <= '0; phase <= PH_DW;
              end else begin
                sum <= add_r;
                if (last_k) begin k <= '0; us <= us + 1'b1; end else k <= k + 1'b1;
              end
              state <= S_RD;
            end
            PH_DW: begin dw <= mres; vs <= '0; phase <= PH_LAP; sub <= 2'd0; state <= S_RD; end
            PH_LAP: begin
              if (sub == 2'd1) begin
                ta <= tc; tb <= mres; state <= S_M3;  // u * (g.g)
              end else begin
                ta <= mres; tb <= w; state <= S_M3;   // (pr*g) * w
              end
            end
            default: state <= S_ACC;
          endcase
        end
        S_M3: begin
          if (sub == 2'd1) begin
            if (last_k && last_us) begin
              // lap done: velocity row update
              ta <= nw; tb <= sat32(add_r); acc_r <= acc_rd; sum <= '0;
              state <= S_ACC;
            end else begin
              sum <= add_r; sub <= 2'd0;
              if (last_k) begin k <= '0; us <= us + 1'b1; end else k <= k + 1'b1;
              state <= S_RD;
            end
          end else state <= S_ACC;
        end
        S_ACC: begin
          if (phase == PH_PRS) begin
            us <= '0;
            if (5'(vs) + 5'd1 == npr) state <= S_NEXT;
            else begin vs <= vs + 1'b1; state <= S_RD; end
          end else if (sub == 2'd1) begin
            acc_r <= add_r; sub <= 2'd2; state <= S_RD;
          end else begin
            sub <= 2'd0; us <= '0; k <= '0;
            if (last_vs) begin
              vs <= '0;
              if (32'(vd) == Dim - 1) begin phase <= PH_PRS; end
              else vd <= vd + 1'b1;
            end else vs <= vs + 1'b1;
            state <= S_RD;
          end
        end
        S_NEXT: begin
          if (5'(p) + 5'd1 == np) begin
            o_f <= '0; o_s <= '0; state <= S_ERD;
          end else begin p <= p + 1'b1; state <= S_PT; end
        end
        S_ERD: state <= S_EWAIT;
        S_EWAIT: begin
          out_func <= o_f; out_shape <= o_s; defect_value <= sat32(acc_rd);
          last_flag <= (32'(o_f) == Dim) && (5'(o_s) + 5'd1 == npr);
          out_valid <= 1'b1; state <= S_EOUT;
        end
        S_EOUT: if (out_ready) begin
          out_valid <= 1'b0;
          if (last_flag) state <= S_IDLE;
          else begin
            if ((32'(o_f) < Dim) ? (5'(o_s) + 5'd1 == nv) : 1'b0) begin
              o_f <= o_f + 1'b1; o_s <= '0;
            end else o_s <= o_s + 1'b1;
            state <= S_ERD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
